// File: rtl/core/rrt_pkg.sv
// Package for the 3D tree extension block: widths, defaults, register indexes, FSM states.
// No dependencies.
package rrt_pkg;
  localparam int MAX_NODES_DEF = 1024;
  localparam int FRAC_BITS_DEF = 10;
  localparam int CoordW = 16;
  localparam int PointW = 48;
  localparam int IdxOutW = 10;
  localparam int CfgIdxW = 3;
  localparam int BiasPeriod = 10;

  localparam logic [CfgIdxW-1:0] REG_START = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_GOAL = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_GOAL_R = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_OBS = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_OBS_R = 3'd4;
  localparam logic [CfgIdxW-1:0] REG_STEP = 3'd5;
  localparam logic [CfgIdxW-1:0] REG_ITER = 3'd6;

  typedef enum logic [3:0] {
    ST_IDLE, ST_SCAN, ST_SCAN_LAST, ST_DECIDE, ST_SQRT, ST_DIV, ST_CHECK, ST_HIT,
    ST_DONE
  } rrt_state_t;

  // |a-b| for coordinates
  function automatic logic [CoordW-1:0] absdiff(input logic [CoordW-1:0] a,
                                                input logic [CoordW-1:0] b);
    return (a >= b) ? a - b : b - a;
  endfunction
endpackage

// File: rtl/core/rrt_div.sv
// Restoring divider, one quotient bit per cycle.
// Depends on rrt_pkg (nothing beyond import convention).
module rrt_div import rrt_pkg::*; #(
  parameter int NumW = 36,
  parameter int DenW = 17
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            go,
  input  logic [NumW-1:0] num,
  input  logic [DenW-1:0] den,
  output logic            done,
  output logic [NumW-1:0] quo
);
  localparam int CntW = $clog2(NumW + 1);
  logic [NumW-1:0] q_r, q_nxt;
  logic [DenW:0] rem_r, rem_nxt;
  logic [DenW-1:0] den_r, den_nxt;
  logic [CntW-1:0] cnt_r, cnt_nxt;
  logic busy_r, busy_nxt;
  logic done_r, done_nxt;
  logic [DenW:0] sh;

  always_comb begin
    q_nxt = q_r;
    rem_nxt = rem_r;
    den_nxt = den_r;
    cnt_nxt = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    sh = {rem_r[DenW-1:0], q_r[NumW-1]};
    if (go) begin
      q_nxt = num;
      rem_nxt = '0;
      den_nxt = den;
      cnt_nxt = CntW'(NumW);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (sh >= {1'b0, den_r}) begin
        rem_nxt = sh - {1'b0, den_r};
        q_nxt = {q_r[NumW-2:0], 1'b1};
      end else begin
        rem_nxt = sh;
        q_nxt = {q_r[NumW-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 1'b1;
      // flag completion once the last quotient bit is in q_r
      if (cnt_r == CntW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r <= '0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r <= cnt_nxt;
      done_r <= done_nxt;
    end
    q_r <= q_nxt;
    rem_r <= rem_nxt;
    den_r <= den_nxt;
  end
  assign done = done_r;
  assign quo = q_r;
endmodule

// File: rtl/core/rrt_tree_extend_3d.sv
// Top level of the 3D tree extension block: node memory, nearest-node scan, steering.
// Depends on rrt_pkg and rrt_div.
//
//  channel | ports                                   | handshake
//  in      | in_sample_x/y/z                         | start & !busy
//  out     | out_node_index .. out_finished          | out_valid, one cycle
//  cfg     | cfg_index, cfg_data                     | cfg_valid & cfg_ready
//
// Per item: the scan reads one node per scan step, then the block decides,
// checks and outputs the result; a clipped step adds a square root, one division
// per axis and a reload of the divider between divisions (ST_HIT); a step after
// finish goes straight to the output.
// Reset is synchronous: node 0 sits in a register, the memory needs no clearing.
// The receiver cannot stall; cfg_ready is high whenever busy is low.
module rrt_tree_extend_3d import rrt_pkg::*; #(
  parameter int MAX_NODES = MAX_NODES_DEF,
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  logic [CoordW-1:0]    in_sample_x,
  input  logic [CoordW-1:0]    in_sample_y,
  input  logic [CoordW-1:0]    in_sample_z,
  output logic                 out_valid,
  output logic [IdxOutW-1:0]   out_node_index,
  output logic [IdxOutW-1:0]   out_parent_index,
  output logic [CoordW-1:0]    out_node_x,
  output logic [CoordW-1:0]    out_node_y,
  output logic [CoordW-1:0]    out_node_z,
  output logic                 out_accepted,
  output logic                 out_goal_reached,
  output logic                 out_finished,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CfgIdxW-1:0]   cfg_index,
  input  logic [PointW-1:0]    cfg_data
);
  localparam int AW = $clog2(MAX_NODES);
  localparam int CW = AW + 1;
  localparam int EntW = PointW + AW;
  localparam int D2W = 2 * CoordW + 2;
  localparam int NumW = 2 * CoordW + 2;
  localparam logic [CoordW-1:0] ONE = CoordW'(1) << FRAC_BITS;

  // configuration
  logic [PointW-1:0] start_r, goal_r, obs_r;
  logic [CoordW-1:0] goal_rad_r, obs_rad_r, step_r, iter_lim_r;

  logic [EntW-1:0] mem [MAX_NODES];
  logic [EntW-1:0] rd_q;
  logic [AW-1:0] rd_addr;
  logic rd_en, wr_en;
  logic [AW-1:0] wr_addr;
  logic [EntW-1:0] wr_data;

  rrt_state_t st_r, st_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic [CoordW-1:0] iter_r, iter_nxt;
  logic done_r, done_nxt;
  logic [3:0] bias_r, bias_nxt;
  logic [CW-1:0] scan_r, scan_nxt;      // index being read
  logic [AW-1:0] cmp_idx_r, cmp_idx_nxt; // index whose data is in rd_q
  logic [CoordW-1:0] tx_r, ty_r, tz_r, tx_nxt, ty_nxt, tz_nxt;
  logic [D2W-1:0] best_d_r, best_d_nxt;
  logic [AW-1:0] best_r, best_nxt;
  logic [PointW-1:0] bestp_r, bestp_nxt;
  logic [CoordW-1:0] px_r, py_r, pz_r, px_nxt, py_nxt, pz_nxt;
  logic [1:0] axis_r, axis_nxt;
  // square root state
  logic [D2W-1:0] sq_v_r, sq_v_nxt, sq_r_r, sq_r_nxt, sq_b_r, sq_b_nxt;
  logic out_valid_r, out_valid_nxt;
  logic [IdxOutW-1:0] o_ni_r, o_ni_nxt, o_pi_r, o_pi_nxt;
  logic o_acc_r, o_acc_nxt, o_gr_r, o_gr_nxt, o_fin_r, o_fin_nxt;
  logic hit_r, hit_nxt;
  logic [D2W-1:0] gd_r, gd_nxt;

  logic div_go, div_done;
  logic [NumW-1:0] div_num, div_quo;
  logic [CoordW+1:0] div_den;

  logic [PointW-1:0] cur_p;
  logic [D2W-1:0] cur_d;
  logic [CoordW-1:0] dx, dy, ax, at;
  logic [2*CoordW-1:0] step2, obs2, goal2;

  function automatic logic [D2W-1:0] d2(input logic [PointW-1:0] a,
                                        input logic [PointW-1:0] b);
    logic [CoordW-1:0] e0, e1, e2;
    e0 = absdiff(a[47:32], b[47:32]);
    e1 = absdiff(a[31:16], b[31:16]);
    e2 = absdiff(a[15:0], b[15:0]);
    return D2W'(e0) * D2W'(e0) + D2W'(e1) * D2W'(e1) + D2W'(e2) * D2W'(e2);
  endfunction

  assign busy = (st_r != ST_IDLE);
  assign cfg_ready = !busy;
  assign step2 = step_r * step_r;
  assign obs2 = obs_rad_r * obs_rad_r;
  assign goal2 = goal_rad_r * goal_rad_r;

  // node 0 lives in the start register
  assign cur_p = (cmp_idx_r == '0) ? start_r : rd_q[EntW-1 -: PointW];
  assign cur_d = d2(cur_p, {tx_r, ty_r, tz_r});

  always_comb begin
    case (axis_r)
      2'd0: begin ax = bestp_r[47:32]; at = tx_r; end
      2'd1: begin ax = bestp_r[31:16]; at = ty_r; end
      default: begin ax = bestp_r[15:0]; at = tz_r; end
    endcase
  end
  assign dx = absdiff(ax, at);
  assign div_num = (NumW'(step_r) * NumW'(dx) << 1) + NumW'(sq_r_r[CoordW:0]);
  assign div_den = {sq_r_r[CoordW:0], 1'b0};

  rrt_div #(.NumW(NumW), .DenW(CoordW + 2)) u_div (
    .clk(clk), .rst_n(rst_n), .go(div_go), .num(div_num), .den(div_den),
    .done(div_done), .quo(div_quo)
  );

  always_comb begin
    st_nxt = st_r;
    count_nxt = count_r;
    iter_nxt = iter_r;
    done_nxt = done_r;
    bias_nxt = bias_r;
    scan_nxt = scan_r;
    cmp_idx_nxt = cmp_idx_r;
    tx_nxt = tx_r; ty_nxt = ty_r; tz_nxt = tz_r;
    best_d_nxt = best_d_r; best_nxt = best_r; bestp_nxt = bestp_r;
    px_nxt = px_r; py_nxt = py_r; pz_nxt = pz_r;
    axis_nxt = axis_r;
    sq_v_nxt = sq_v_r; sq_r_nxt = sq_r_r; sq_b_nxt = sq_b_r;
    out_valid_nxt = 1'b0;
    o_ni_nxt = o_ni_r; o_pi_nxt = o_pi_r;
    o_acc_nxt = o_acc_r; o_gr_nxt = o_gr_r; o_fin_nxt = o_fin_r;
    hit_nxt = hit_r; gd_nxt = gd_r;
    rd_en = 1'b0; rd_addr = scan_r[AW-1:0];
    wr_en = 1'b0; wr_addr = count_r[AW-1:0];
    wr_data = {px_r, py_r, pz_r, best_r};
    div_go = 1'b0;
    dy = '0;
    case (st_r)
      ST_IDLE: begin
        if (start) begin
          if (done_r) begin
            st_nxt = ST_DONE;
          end else begin
            if (bias_r == 4'd0) begin
              tx_nxt = goal_r[47:32]; ty_nxt = goal_r[31:16]; tz_nxt = goal_r[15:0];
            end else begin
              tx_nxt = in_sample_x; ty_nxt = in_sample_y; tz_nxt = in_sample_z;
            end
            rd_en = 1'b1;
            rd_addr = '0;
            cmp_idx_nxt = '0;
            scan_nxt = CW'(1);
            st_nxt = (count_r == CW'(1)) ? ST_SCAN_LAST : ST_SCAN;
          end
        end
      end
      ST_SCAN, ST_SCAN_LAST: begin
        // compare the node read last cycle; in ST_SCAN also read the next
        if (cmp_idx_r == '0 || cur_d < best_d_r) begin
          best_d_nxt = cur_d; best_nxt = cmp_idx_r; bestp_nxt = cur_p;
        end
        if (st_r == ST_SCAN) begin
          rd_en = 1'b1;
          cmp_idx_nxt = scan_r[AW-1:0];
          scan_nxt = scan_r + 1'b1;
          if (scan_r + 1'b1 == count_r) st_nxt = ST_SCAN_LAST;
        end else begin
          st_nxt = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        if (best_d_r <= D2W'(step2)) begin
          px_nxt = tx_r; py_nxt = ty_r; pz_nxt = tz_r;
          st_nxt = ST_CHECK;
        end else begin
          sq_v_nxt = best_d_r;
          sq_r_nxt = '0;
          sq_b_nxt = D2W'(1) << (D2W - 2);
          // x operands must be in place when the first division starts
          axis_nxt = 2'd0;
          st_nxt = ST_SQRT;
        end
      end
      ST_SQRT: begin
        if (sq_b_r == '0) begin
          div_go = 1'b1;
          st_nxt = ST_DIV;
        end else begin
          if (sq_v_r >= sq_r_r + sq_b_r) begin
            sq_v_nxt = sq_v_r - (sq_r_r + sq_b_r);
            sq_r_nxt = (sq_r_r >> 1) + sq_b_r;
          end else begin
            sq_r_nxt = sq_r_r >> 1;
          end
          sq_b_nxt = sq_b_r >> 2;
        end
      end
      ST_DIV: begin
        if (div_done) begin
          dy = (at >= ax) ? ax + div_quo[CoordW-1:0] : ax - div_quo[CoordW-1:0];
          case (axis_r)
            2'd0: px_nxt = dy;
            2'd1: py_nxt = dy;
            default: pz_nxt = dy;
          endcase
          if (axis_r == 2'd2) begin
            st_nxt = ST_CHECK;
          end else begin
            axis_nxt = axis_r + 1'b1;
            st_nxt = ST_HIT;
          end
        end
      end
      ST_HIT: begin
        // let the next axis operands settle, then restart the divider
        div_go = 1'b1;
        st_nxt = ST_DIV;
      end
      ST_CHECK: begin
        hit_nxt = d2({px_r, py_r, pz_r}, obs_r) <= D2W'(obs2);
        gd_nxt = d2({px_r, py_r, pz_r}, goal_r);
        st_nxt = ST_DONE;
      end
      ST_DONE: begin
        out_valid_nxt = 1'b1;
        st_nxt = ST_IDLE;
        if (done_r) begin
          o_ni_nxt = '0; o_pi_nxt = '0; o_acc_nxt = 1'b0; o_gr_nxt = 1'b0;
          o_fin_nxt = 1'b1;
          px_nxt = '0; py_nxt = '0; pz_nxt = '0;
        end else begin
          o_acc_nxt = !hit_r && count_r < CW'(MAX_NODES);
          o_gr_nxt = gd_r <= D2W'(goal2);
          o_pi_nxt = IdxOutW'(best_r);
          o_ni_nxt = o_acc_nxt ? IdxOutW'(count_r) : '0;
          if (o_acc_nxt) begin
            wr_en = 1'b1;
            count_nxt = count_r + 1'b1;
          end
          o_fin_nxt = o_gr_nxt || iter_r >= iter_lim_r || count_nxt >= CW'(MAX_NODES);
          if (o_fin_nxt) begin
            done_nxt = 1'b1;
          end else begin
            iter_nxt = iter_r + 1'b1;
            bias_nxt = (bias_r == 4'(BiasPeriod - 1)) ? 4'd0 : bias_r + 1'b1;
          end
        end
      end
      default: st_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    if (rd_en) rd_q <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ST_IDLE;
      count_r <= CW'(1);
      iter_r <= '0;
      done_r <= 1'b0;
      bias_r <= '0;
      out_valid_r <= 1'b0;
      start_r <= '0; goal_r <= '0; obs_r <= '0;
      goal_rad_r <= ONE; obs_rad_r <= '0; step_r <= ONE; iter_lim_r <= 16'd1000;
    end else begin
      st_r <= st_nxt;
      count_r <= count_nxt;
      iter_r <= iter_nxt;
      done_r <= done_nxt;
      bias_r <= bias_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_START: start_r <= cfg_data;
          REG_GOAL: goal_r <= cfg_data;
          REG_GOAL_R: goal_rad_r <= cfg_data[CoordW-1:0];
          REG_OBS: obs_r <= cfg_data;
          REG_OBS_R: obs_rad_r <= cfg_data[CoordW-1:0];
          REG_STEP: step_r <= cfg_data[CoordW-1:0];
          REG_ITER: iter_lim_r <= cfg_data[CoordW-1:0];
          default: ;
        endcase
      end
    end
    scan_r <= scan_nxt; cmp_idx_r <= cmp_idx_nxt;
    tx_r <= tx_nxt; ty_r <= ty_nxt; tz_r <= tz_nxt;
    best_d_r <= best_d_nxt; best_r <= best_nxt; bestp_r <= bestp_nxt;
    px_r <= px_nxt; py_r <= py_nxt; pz_r <= pz_nxt;
    axis_r <= axis_nxt;
    sq_v_r <= sq_v_nxt; sq_r_r <= sq_r_nxt; sq_b_r <= sq_b_nxt;
    o_ni_r <= o_ni_nxt; o_pi_r <= o_pi_nxt;
    o_acc_r <= o_acc_nxt; o_gr_r <= o_gr_nxt; o_fin_r <= o_fin_nxt;
    hit_r <= hit_nxt; gd_r <= gd_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_node_index = o_ni_r;
  assign out_parent_index = o_pi_r;
  assign out_node_x = px_r;
  assign out_node_y = py_r;
  assign out_node_z = pz_r;
  assign out_accepted = o_acc_r;
  assign out_goal_reached = o_gr_r;
  assign out_finished = o_fin_r;
endmodule
